### sv/dpcr_pkg.sv
package dpcr_pkg;

  localparam int IN_W   = 384;
  localparam int OUT_W  = 264;
  localparam int SQRT_W = 32;
  localparam int QUOT_W = 31;
  localparam int FRAC_N = 28;

  typedef enum logic [1:0] {
    OUT_NONE       = 2'd0,
    OUT_RESOLVED   = 2'd1,
    OUT_COINCIDENT = 2'd2
  } outcome_t;

  typedef struct packed {
    logic signed [31:0] pos_x_a;
    logic signed [31:0] pos_y_a;
    logic signed [31:0] vel_x_a;
    logic signed [31:0] vel_y_a;
    logic signed [31:0] pos_x_b;
    logic signed [31:0] pos_y_b;
    logic signed [31:0] vel_x_b;
    logic signed [31:0] vel_y_b;
    logic [30:0]        mass_a;
    logic [30:0]        mass_b;
    logic [31:0]        tm;
    logic [31:0]        s;
    logic [31:0]        adx;
    logic [31:0]        ady;
    logic               neg_x;
    logic               neg_y;
    logic [63:0]        sq;
    outcome_t           outcome;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic signed [31:0] qx;
    logic signed [31:0] qy;
    logic signed [29:0] nx;
    logic signed [29:0] ny;
    logic [29:0]        wa;
    logic [29:0]        wb;
    logic signed [32:0] dvx;
    logic signed [32:0] dvy;
  } mid_t;

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    logic signed [31:0] r;
    if (v[37:31] == 7'h00 || v[37:31] == 7'h7f) begin
      r = v[31:0];
    end else if (v[37]) begin
      r = 32'sh80000000;
    end else begin
      r = 32'sh7fffffff;
    end
    return r;
  endfunction

endpackage

### sv/disc_pair_collision_resolver_unit.sv
// throughput: one disc pair per cycle, sustained while the output is taken
// the back end is a 71-stage pipeline set by the 32-stage root and 31-stage dividers
// a 4-entry queue lets the front keep accepting while the back end is held
// reset clears all valid bits and queue pointers; no clearing pass is needed
module disc_pair_collision_resolver_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // pos_x_a, pos_y_a, vel_x_a, vel_y_a, radius_a, mass_a,
  // pos_x_b, pos_y_b, vel_x_b, vel_y_b, radius_b, mass_b, zero fill
  input  logic [dpcr_pkg::IN_W-1:0]   s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // outcome, new_pos_x_a, new_pos_y_a, new_vel_x_a, new_vel_y_a,
  // new_pos_x_b, new_pos_y_b, new_vel_x_b, new_vel_y_b, zero fill
  output logic [dpcr_pkg::OUT_W-1:0]  m_tdata
);
  import dpcr_pkg::*;

  q_status_t q_status;
  item_t     wr_item, rd_item;
  logic      push, pop;

  dpcr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_status (q_status),
    .q_pop    (pop),
    .push     (push),
    .wr_item  (wr_item)
  );

  dpcr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (rd_item),
    .status  (q_status)
  );

  dpcr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .q_item   (rd_item),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

### sv/dpcr_sqrt.sv
module dpcr_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] radicand,
  output logic [31:0] root
);
  import dpcr_pkg::*;

  logic [33:0]       rem  [SQRT_W];
  logic [SQRT_W-1:0] part [SQRT_W];
  logic [63:0]       rad  [SQRT_W];

  for (genvar i = 0; i < SQRT_W; i++) begin : g_stage
    logic [33:0]       r_in;
    logic [SQRT_W-1:0] q_in;
    logic [63:0]       a_in;
    logic [35:0]       cur;
    logic [35:0]       trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign r_in = '0;
      assign q_in = '0;
      assign a_in = radicand;
    end else begin : g_next
      assign r_in = rem[i-1];
      assign q_in = part[i-1];
      assign a_in = rad[i-1];
    end

    assign cur   = {r_in, a_in[63:62]};
    assign trial = {2'b00, q_in, 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]  <= ge ? 34'(cur - trial) : cur[33:0];
        part[i] <= {q_in[SQRT_W-2:0], ge};
        rad[i]  <= {a_in[61:0], 2'b00};
      end
    end
  end

  assign root = part[SQRT_W-1];

endmodule

### sv/dpcr_div.sv
module dpcr_div #(
  parameter int NUM_W  = 64,
  parameter int DEN_W  = 33,
  parameter int QUOT_W = 31
) (
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  numer,
  input  logic [DEN_W-1:0]  denom,
  output logic [QUOT_W-1:0] quot
);

  logic [DEN_W-1:0]  rem [QUOT_W];
  logic [DEN_W-1:0]  den [QUOT_W];
  logic [QUOT_W-1:0] qb  [QUOT_W];
  logic [QUOT_W-1:0] low [QUOT_W];

  for (genvar i = 0; i < QUOT_W; i++) begin : g_stage
    logic [DEN_W-1:0]  r_in;
    logic [DEN_W-1:0]  d_in;
    logic [QUOT_W-1:0] q_in;
    logic [QUOT_W-1:0] n_in;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign r_in = DEN_W'(numer >> QUOT_W);
      assign d_in = denom;
      assign q_in = '0;
      assign n_in = numer[QUOT_W-1:0];
    end else begin : g_next
      assign r_in = rem[i-1];
      assign d_in = den[i-1];
      assign q_in = qb[i-1];
      assign n_in = low[i-1];
    end

    assign trial = {r_in, n_in[QUOT_W-1]};
    assign diff  = trial - {1'b0, d_in};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        den[i] <= d_in;
        qb[i]  <= {q_in[QUOT_W-2:0], ge};
        low[i] <= {n_in[QUOT_W-2:0], 1'b0};
      end
    end
  end

  assign quot = qb[QUOT_W-1];

endmodule

### sv/dpcr_front.sv
module dpcr_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [dpcr_pkg::IN_W-1:0]  s_tdata,
  input  dpcr_pkg::q_status_t        q_status,
  input  logic                       q_pop,
  output logic                       push,
  output dpcr_pkg::item_t            wr_item
);
  import dpcr_pkg::*;

  logic               en;
  logic               space;
  logic               f1_valid, f2_valid, f3_valid;
  item_t              in_item;
  item_t              f1_item, f2_item, f3_item;
  item_t              f2_item_next;
  logic signed [32:0] dx_in, dy_in;
  logic signed [32:0] f1_dx, f1_dy;
  logic signed [32:0] ndx, ndy;
  logic [31:0]        adx, ady;
  logic               f2_box, f2_zero, f3_box, f3_zero;
  logic [63:0]        sx, sy, s2;
  logic [64:0]        sq;
  logic               contact;

  always_comb begin
    in_item         = '0;
    in_item.pos_x_a = s_tdata[31:0];
    in_item.pos_y_a = s_tdata[63:32];
    in_item.vel_x_a = s_tdata[95:64];
    in_item.vel_y_a = s_tdata[127:96];
    in_item.mass_a  = s_tdata[189:159];
    in_item.pos_x_b = s_tdata[221:190];
    in_item.pos_y_b = s_tdata[253:222];
    in_item.vel_x_b = s_tdata[285:254];
    in_item.vel_y_b = s_tdata[317:286];
    in_item.mass_b  = s_tdata[379:349];
    in_item.s       = {1'b0, s_tdata[158:128]} + {1'b0, s_tdata[348:318]};
    in_item.tm      = {1'b0, s_tdata[189:159]} + {1'b0, s_tdata[379:349]};
    in_item.outcome = OUT_NONE;
  end

  assign dx_in = {s_tdata[31], s_tdata[31:0]} - {s_tdata[221], s_tdata[221:190]};
  assign dy_in = {s_tdata[63], s_tdata[63:32]} - {s_tdata[253], s_tdata[253:222]};

  assign ndx = -f1_dx;
  assign ndy = -f1_dy;
  assign adx = f1_dx[32] ? ndx[31:0] : f1_dx[31:0];
  assign ady = f1_dy[32] ? ndy[31:0] : f1_dy[31:0];

  always_comb begin
    f2_item_next       = f1_item;
    f2_item_next.adx   = adx;
    f2_item_next.ady   = ady;
    f2_item_next.neg_x = f1_dx[32];
    f2_item_next.neg_y = f1_dy[32];
  end

  assign space    = !q_status.full || q_pop;
  assign en       = !f3_valid || space;
  assign s_tready = en;
  assign push     = f3_valid && space;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      f3_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= s_tvalid;
      f2_valid <= f1_valid;
      f3_valid <= f2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_item <= in_item;
      f1_dx   <= dx_in;
      f1_dy   <= dy_in;

      f2_item <= f2_item_next;
      f2_box  <= (adx <= f1_item.s) && (ady <= f1_item.s);
      f2_zero <= (f1_dx == 33'sd0) && (f1_dy == 33'sd0);

      f3_item <= f2_item;
      f3_box  <= f2_box;
      f3_zero <= f2_zero;
      sx      <= f2_item.adx * f2_item.adx;
      sy      <= f2_item.ady * f2_item.ady;
      s2      <= f2_item.s * f2_item.s;
    end
  end

  assign sq      = {1'b0, sx} + {1'b0, sy};
  assign contact = f3_box && !sq[64] && (sq[63:0] <= s2);

  always_comb begin
    wr_item    = f3_item;
    wr_item.sq = sq[63:0];
    if (!contact) begin
      wr_item.outcome = OUT_NONE;
    end else if (f3_zero) begin
      wr_item.outcome = OUT_COINCIDENT;
    end else begin
      wr_item.outcome = OUT_RESOLVED;
    end
  end

endmodule

### sv/dpcr_queue.sv
module dpcr_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dpcr_pkg::item_t     wr_item,
  input  logic                pop,
  output dpcr_pkg::item_t     rd_item,
  output dpcr_pkg::q_status_t status
);
  import dpcr_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign rd_item      = mem[rd_ptr];
  assign status.full  = count == CW'(DEPTH);
  assign status.empty = count == '0;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!status.full || pop)) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty) else $error("queue read while empty");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count lost a transfer");
`endif

endmodule

### sv/dpcr_back.sv
module dpcr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  dpcr_pkg::q_status_t         q_status,
  input  dpcr_pkg::item_t             q_item,
  output logic                        q_pop,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [dpcr_pkg::OUT_W-1:0]  m_tdata
);
  import dpcr_pkg::*;

  localparam int T_SQ   = SQRT_W;
  localparam int T_L1   = T_SQ + 1;
  localparam int T_L2   = T_SQ + 2;
  localparam int T_DIV  = T_L2 + QUOT_W;
  localparam int MID_N  = 5;
  localparam int T_LAST = T_DIV + MID_N;
  localparam int PIPE_N = T_LAST + 1;

  logic                en;
  logic [PIPE_N-1:0]   vld;
  item_t               pipe [PIPE_N];
  mid_t                mid  [MID_N];
  mid_t                m1;

  logic [31:0]         root;
  logic [31:0]         ov, len1, len2;
  logic [63:0]         px, py;
  logic [QUOT_W-1:0]   qxm, qym, nxm, nym, wam, wbm;

  logic signed [62:0]  pdx, pdy;
  logic signed [63:0]  psum;
  logic signed [35:0]  rel;
  logic signed [66:0]  pja, pjb;
  logic signed [35:0]  ja, jb;
  logic signed [65:0]  pax, pay, pbx, pby;
  logic signed [35:0]  tax, tay, tbx, tby;

  logic signed [37:0]  npxa, npya, npxb, npyb, nvxa, nvya, nvxb, nvyb;
  item_t               fin;
  logic                out_valid;
  logic [OUT_W-1:0]    out_data;

  assign en    = !out_valid || m_tready;
  assign q_pop = en && !q_status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[PIPE_N-2:0], q_pop};
      out_valid <= vld[PIPE_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= q_item;
      for (int k = 1; k < PIPE_N; k++) begin
        pipe[k] <= pipe[k-1];
      end
      mid[0] <= m1;
      for (int k = 1; k < MID_N; k++) begin
        mid[k] <= mid[k-1];
      end
    end
  end

  dpcr_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (pipe[0].sq),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      ov   <= pipe[T_SQ].s - root;
      len1 <= root;
      px   <= ov * pipe[T_L1].adx;
      py   <= ov * pipe[T_L1].ady;
      len2 <= len1;
    end
  end

  dpcr_div #(.NUM_W(64), .DEN_W(33), .QUOT_W(QUOT_W)) u_div_qx (
    .clk (clk), .en (en), .numer (px), .denom ({len2, 1'b0}), .quot (qxm)
  );
  dpcr_div #(.NUM_W(64), .DEN_W(33), .QUOT_W(QUOT_W)) u_div_qy (
    .clk (clk), .en (en), .numer (py), .denom ({len2, 1'b0}), .quot (qym)
  );
  dpcr_div #(.NUM_W(60), .DEN_W(32), .QUOT_W(QUOT_W)) u_div_nx (
    .clk (clk), .en (en), .numer ({pipe[T_L2].adx, 28'd0}), .denom (len2), .quot (nxm)
  );
  dpcr_div #(.NUM_W(60), .DEN_W(32), .QUOT_W(QUOT_W)) u_div_ny (
    .clk (clk), .en (en), .numer ({pipe[T_L2].ady, 28'd0}), .denom (len2), .quot (nym)
  );
  dpcr_div #(.NUM_W(60), .DEN_W(32), .QUOT_W(QUOT_W)) u_div_wa (
    .clk (clk), .en (en), .numer ({pipe[T_L2].mass_b, 29'd0}), .denom (pipe[T_L2].tm),
    .quot (wam)
  );
  dpcr_div #(.NUM_W(60), .DEN_W(32), .QUOT_W(QUOT_W)) u_div_wb (
    .clk (clk), .en (en), .numer ({pipe[T_L2].mass_a, 29'd0}), .denom (pipe[T_L2].tm),
    .quot (wbm)
  );

  // signs back on, unit weights when both masses are zero
  always_comb begin
    m1.qx  = pipe[T_DIV].neg_x ? -$signed({1'b0, qxm}) : $signed({1'b0, qxm});
    m1.qy  = pipe[T_DIV].neg_y ? -$signed({1'b0, qym}) : $signed({1'b0, qym});
    m1.nx  = pipe[T_DIV].neg_x ? -$signed({1'b0, nxm[28:0]}) : $signed({1'b0, nxm[28:0]});
    m1.ny  = pipe[T_DIV].neg_y ? -$signed({1'b0, nym[28:0]}) : $signed({1'b0, nym[28:0]});
    m1.wa  = (pipe[T_DIV].tm == '0) ? (30'd1 << FRAC_N) : wam[29:0];
    m1.wb  = (pipe[T_DIV].tm == '0) ? (30'd1 << FRAC_N) : wbm[29:0];
    m1.dvx = {pipe[T_DIV].vel_x_a[31], pipe[T_DIV].vel_x_a}
           - {pipe[T_DIV].vel_x_b[31], pipe[T_DIV].vel_x_b};
    m1.dvy = {pipe[T_DIV].vel_y_a[31], pipe[T_DIV].vel_y_a}
           - {pipe[T_DIV].vel_y_b[31], pipe[T_DIV].vel_y_b};
  end

  assign psum = pdx + pdy;
  assign pja  = rel * $signed({1'b0, mid[2].wa});
  assign pjb  = rel * $signed({1'b0, mid[2].wb});
  assign pax  = ja * mid[3].nx;
  assign pay  = ja * mid[3].ny;
  assign pbx  = jb * mid[3].nx;
  assign pby  = jb * mid[3].ny;

  always_ff @(posedge clk) begin
    if (en) begin
      pdx <= mid[0].dvx * mid[0].nx;
      pdy <= mid[0].dvy * mid[0].ny;
      rel <= psum[63:28];
      ja  <= pja[63:28];
      jb  <= pjb[63:28];
      tax <= pax[63:28];
      tay <= pay[63:28];
      tbx <= pbx[63:28];
      tby <= pby[63:28];
    end
  end

  assign fin  = pipe[T_LAST];
  assign npxa = fin.pos_x_a + mid[4].qx;
  assign npya = fin.pos_y_a + mid[4].qy;
  assign npxb = fin.pos_x_b - mid[4].qx;
  assign npyb = fin.pos_y_b - mid[4].qy;
  assign nvxa = fin.vel_x_a - tax;
  assign nvya = fin.vel_y_a - tay;
  assign nvxb = fin.vel_x_b + tbx;
  assign nvyb = fin.vel_y_b + tby;

  always_ff @(posedge clk) begin
    if (en) begin
      if (fin.outcome == OUT_RESOLVED) begin
        out_data <= {6'd0, sat32(nvyb), sat32(nvxb), sat32(npyb), sat32(npxb),
                     sat32(nvya), sat32(nvxa), sat32(npya), sat32(npxa), fin.outcome};
      end else begin
        out_data <= {6'd0, fin.vel_y_b, fin.vel_x_b, fin.pos_y_b, fin.pos_x_b,
                     fin.vel_y_a, fin.vel_x_a, fin.pos_y_a, fin.pos_x_a, fin.outcome};
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

### verif/tb.sv
module tb;
  import dpcr_pkg::*;

  typedef struct packed {
    logic [30:0]        mass_b;
    logic [30:0]        radius_b;
    logic signed [31:0] vel_y_b;
    logic signed [31:0] vel_x_b;
    logic signed [31:0] pos_y_b;
    logic signed [31:0] pos_x_b;
    logic [30:0]        mass_a;
    logic [30:0]        radius_a;
    logic signed [31:0] vel_y_a;
    logic signed [31:0] vel_x_a;
    logic signed [31:0] pos_y_a;
    logic signed [31:0] pos_x_a;
  } disc_pair_t;

  typedef struct packed {
    logic signed [31:0] new_vel_y_b;
    logic signed [31:0] new_vel_x_b;
    logic signed [31:0] new_pos_y_b;
    logic signed [31:0] new_pos_x_b;
    logic signed [31:0] new_vel_y_a;
    logic signed [31:0] new_vel_x_a;
    logic signed [31:0] new_pos_y_a;
    logic signed [31:0] new_pos_x_a;
    outcome_t           outcome;
  } contact_t;

  typedef logic signed [127:0] wide_t;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic [OUT_W-1:0]  m_tdata;

  disc_pair_t pair_q[$];
  contact_t   contact_q[$];
  disc_pair_t cur_pair;
  int         errors;
  int         send_gap;
  int         recv_hold;
  bit         send_calm;
  bit         recv_calm;
  bit         long_hold_done;
  int         taken;

  disc_pair_collision_resolver_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic wide_t int_root(wide_t v);
    wide_t root;
    wide_t trial;
    root = 0;
    for (int i = 32; i >= 0; i--) begin
      trial = root | (wide_t'(1) << i);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic logic signed [31:0] clamp32(wide_t v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic contact_t resolve_pair(disc_pair_t p);
    contact_t r;
    wide_t xa, ya, xb, yb, vxa, vya, vxb, vyb, ra, rb, ma, mb;
    wide_t dx, dy, adx, ady, s, sq, len, ov, qx, qy, nx, ny, tm, wa, wb, rel, ja, jb;
    r.outcome = OUT_NONE;
    r.new_pos_x_a = p.pos_x_a; r.new_pos_y_a = p.pos_y_a;
    r.new_vel_x_a = p.vel_x_a; r.new_vel_y_a = p.vel_y_a;
    r.new_pos_x_b = p.pos_x_b; r.new_pos_y_b = p.pos_y_b;
    r.new_vel_x_b = p.vel_x_b; r.new_vel_y_b = p.vel_y_b;
    xa = wide_t'(p.pos_x_a); ya = wide_t'(p.pos_y_a);
    vxa = wide_t'(p.vel_x_a); vya = wide_t'(p.vel_y_a);
    xb = wide_t'(p.pos_x_b); yb = wide_t'(p.pos_y_b);
    vxb = wide_t'(p.vel_x_b); vyb = wide_t'(p.vel_y_b);
    ra = {97'b0, p.radius_a}; rb = {97'b0, p.radius_b};
    ma = {97'b0, p.mass_a}; mb = {97'b0, p.mass_b};
    dx = xa - xb; dy = ya - yb;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    s = ra + rb;
    if (adx <= s && ady <= s) begin
      sq = adx * adx + ady * ady;
      if (sq <= s * s) begin
        if (dx == 0 && dy == 0) begin
          r.outcome = OUT_COINCIDENT;
        end else begin
          len = int_root(sq);
          ov = s - len;
          qx = (ov * adx) / (2 * len);
          qy = (ov * ady) / (2 * len);
          nx = (adx <<< 28) / len;
          ny = (ady <<< 28) / len;
          if (dx < 0) begin
            qx = -qx; nx = -nx;
          end
          if (dy < 0) begin
            qy = -qy; ny = -ny;
          end
          tm = ma + mb;
          if (tm == 0) begin
            wa = wide_t'(1) <<< 28; wb = wa;
          end else begin
            wa = (mb <<< 29) / tm; wb = (ma <<< 29) / tm;
          end
          rel = ((vxa - vxb) * nx + (vya - vyb) * ny) >>> 28;
          ja = (rel * wa) >>> 28;
          jb = (rel * wb) >>> 28;
          r.outcome = OUT_RESOLVED;
          r.new_pos_x_a = clamp32(xa + qx); r.new_pos_y_a = clamp32(ya + qy);
          r.new_pos_x_b = clamp32(xb - qx); r.new_pos_y_b = clamp32(yb - qy);
          r.new_vel_x_a = clamp32(vxa - ((ja * nx) >>> 28));
          r.new_vel_y_a = clamp32(vya - ((ja * ny) >>> 28));
          r.new_vel_x_b = clamp32(vxb + ((jb * nx) >>> 28));
          r.new_vel_y_b = clamp32(vyb + ((jb * ny) >>> 28));
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) contact_q.push_back(resolve_pair(cur_pair));
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pair_q.size() > 0) begin
          cur_pair = pair_q.pop_front();
          s_tdata <= {4'b0, cur_pair};
          s_tvalid <= 1'b1;
          if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
          send_gap <= pick_gap(send_calm);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    contact_t got;
    contact_t want;
    if (rst) begin
      m_tready <= 1'b0;
      recv_hold <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[257:0];
        taken++;
        if (contact_q.size() == 0) begin
          errors++;
          $display("%0t unexpected transfer %h", $time, got);
        end else begin
          want = contact_q.pop_front();
          check_field("outcome", 32'(want.outcome), 32'(got.outcome));
          check_field("new_pos_x_a", want.new_pos_x_a, got.new_pos_x_a);
          check_field("new_pos_y_a", want.new_pos_y_a, got.new_pos_y_a);
          check_field("new_vel_x_a", want.new_vel_x_a, got.new_vel_x_a);
          check_field("new_vel_y_a", want.new_vel_y_a, got.new_vel_y_a);
          check_field("new_pos_x_b", want.new_pos_x_b, got.new_pos_x_b);
          check_field("new_pos_y_b", want.new_pos_y_b, got.new_pos_y_b);
          check_field("new_vel_x_b", want.new_vel_x_b, got.new_vel_x_b);
          check_field("new_vel_y_b", want.new_vel_y_b, got.new_vel_y_b);
        end
      end
      if (!long_hold_done && taken >= 150) begin
        long_hold_done <= 1'b1;
        recv_hold <= 300;
        m_tready <= 1'b0;
      end else if (recv_hold > 0) begin
        recv_hold <= recv_hold - 1;
        m_tready <= 1'b0;
      end else begin
        if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
        recv_hold <= pick_gap(recv_calm);
        m_tready <= 1'b1;
      end
    end
  end

  function automatic logic signed [31:0] rand_scaled(int k);
    logic [31:0] v;
    v = $urandom;
    if (k < 32) v = {{32{v[k]}} << k} | (v & ((32'd1 << k) - 1));
    return v;
  endfunction

  function automatic disc_pair_t random_pair();
    disc_pair_t p;
    int kind;
    int k;
    longint sum;
    kind = $urandom_range(0, 99);
    k = $urandom_range(3, 30);
    p.pos_x_a = $urandom_range(0, 3) == 0 ? $urandom : rand_scaled(k + 1);
    p.pos_y_a = $urandom_range(0, 3) == 0 ? $urandom : rand_scaled(k + 1);
    p.vel_x_a = $urandom_range(0, 3) == 0 ? $urandom : rand_scaled($urandom_range(4, 31));
    p.vel_y_a = $urandom_range(0, 3) == 0 ? $urandom : rand_scaled($urandom_range(4, 31));
    p.vel_x_b = $urandom_range(0, 3) == 0 ? $urandom : rand_scaled($urandom_range(4, 31));
    p.vel_y_b = $urandom_range(0, 3) == 0 ? $urandom : rand_scaled($urandom_range(4, 31));
    p.radius_a = 31'($urandom_range(0, 7) == 0 ? $urandom_range(1, 32'h7fffffff)
                                               : $urandom_range(1, 32'd1 << k));
    p.radius_b = 31'($urandom_range(0, 7) == 0 ? $urandom_range(1, 32'h7fffffff)
                                               : $urandom_range(1, 32'd1 << k));
    p.mass_a = 31'($urandom_range(0, 3) == 0 ? $urandom_range(1, 32'h7fffffff)
                   : $urandom_range(1, 32'd1 << $urandom_range(1, 30)));
    p.mass_b = 31'($urandom_range(0, 3) == 0 ? $urandom_range(1, 32'h7fffffff)
                   : $urandom_range(1, 32'd1 << $urandom_range(1, 30)));
    sum = longint'(p.radius_a) + longint'(p.radius_b);
    if (sum > 64'h7fffffff) sum = 64'h7fffffff;
    if (kind < 75) begin
      // offset within reach, mostly in contact
      p.pos_x_b = p.pos_x_a - 32'(longint'($urandom_range(0, 2 * 32'(sum))) - sum);
      p.pos_y_b = p.pos_y_a - 32'(longint'($urandom_range(0, 2 * 32'(sum))) - sum);
    end else if (kind < 83) begin
      p.pos_x_b = p.pos_x_a;
      p.pos_y_b = p.pos_y_a;
    end else begin
      p.pos_x_b = $urandom;
      p.pos_y_b = $urandom;
    end
    return p;
  endfunction

  function automatic disc_pair_t make_pair(logic signed [31:0] xa, ya, xb, yb,
                                           logic [30:0] r_a, r_b, m_a, m_b);
    disc_pair_t p;
    p.pos_x_a = xa; p.pos_y_a = ya; p.pos_x_b = xb; p.pos_y_b = yb;
    p.radius_a = r_a; p.radius_b = r_b; p.mass_a = m_a; p.mass_b = m_b;
    p.vel_x_a = $urandom; p.vel_y_a = $urandom;
    p.vel_x_b = $urandom; p.vel_y_b = $urandom;
    return p;
  endfunction

  initial begin
    disc_pair_t p;
    errors = 0;
    taken = 0;
    send_calm = 0;
    recv_calm = 0;
    long_hold_done = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    // no contact, coincident, touching, corner of the box, extreme mass ratios
    pair_q.push_back(make_pair(0, 0, 32'sh00100000, 0, 31'h10000, 31'h10000, 31'h10000, 31'h10000));
    pair_q.push_back(make_pair(5, 7, 5, 7, 1, 1, 1, 1));
    pair_q.push_back(make_pair(0, 0, 2, 0, 1, 1, 31'h10000, 31'h10000));
    pair_q.push_back(make_pair(0, 0, 2, 2, 1, 1, 31'h10000, 31'h10000));
    pair_q.push_back(make_pair(0, 0, 0, -1, 1, 1, 1, 31'h7fffffff));
    pair_q.push_back(make_pair(0, 3, 0, 0, 1, 1, 31'h7fffffff, 1));
    pair_q.push_back(make_pair(0, 0, -3, 0, 1, 1, 31'h7fffffff, 31'h7fffffff));
    // extremes of position and size
    pair_q.push_back(make_pair(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                               31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff));
    pair_q.push_back(make_pair(32'sh7fffffff, 0, 32'sh7ffff000, 0,
                               31'h7fffffff, 31'h7fffffff, 1, 1));
    pair_q.push_back(make_pair(32'sh80000000, 32'sh80000000, 32'sh80000100, 32'sh80000100,
                               31'h7fffffff, 31'h7fffffff, 1, 31'h7fffffff));
    pair_q.push_back(make_pair(32'sh80000000, 0, 32'sh7fffffff, 0,
                               31'h7fffffff, 31'h7fffffff, 31'h10000, 31'h20000));
    pair_q.push_back(make_pair(1, -1, -1, 1, 31'h7fffffff, 31'h7fffffff, 3, 5));
    pair_q.push_back(make_pair(0, 0, 1, 0, 1, 1, 31'h7fffffff, 31'h7fffffff));
    for (int i = 0; i < 4; i++) begin
      p = make_pair(0, 0, 32'sh00008000, 32'sh00008000, 31'h10000, 31'h10000, 31'h10000, 31'h10000);
      p.vel_x_a = i[0] ? 32'sh7fffffff : 32'sh80000000;
      p.vel_y_a = i[1] ? 32'sh7fffffff : 32'sh80000000;
      p.vel_x_b = i[0] ? 32'sh80000000 : 32'sh7fffffff;
      p.vel_y_b = i[1] ? 32'sh80000000 : 32'sh7fffffff;
      pair_q.push_back(p);
    end
    for (int i = 0; i < 850; i++) pair_q.push_back(random_pair());
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (pair_q.size() == 0);
    @(posedge clk);
    while (s_tvalid) @(posedge clk);
    while (contact_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(8 * 400000);
    $display("FAIL");
    $finish;
  end

endmodule

### files.f
sv/dpcr_pkg.sv
sv/dpcr_sqrt.sv
sv/dpcr_div.sv
sv/dpcr_front.sv
sv/dpcr_queue.sv
sv/dpcr_back.sv
sv/disc_pair_collision_resolver_unit.sv
verif/tb.sv
